### hw/rtl/nks_pkg.sv
`timescale 1ns / 1ps

package nks_pkg;

    localparam int NAME_W      = 160;
    localparam int NAME_BYTES  = 20;
    localparam int HANDLE_W    = 16;
    localparam int POS_W       = 10;
    localparam int COUNT_W     = 11;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 176;
    localparam int M_TDATA_W   = 40;
    localparam int M_PAD_W     = M_TDATA_W - HANDLE_W - POS_W - COUNT_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_NOTFOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_CHK,
        ST_SCAN_CMP,
        ST_SHIFT_CHK,
        ST_SHIFT_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [NAME_W-1:0]   name;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_in;
        logic    mem_wr_ins;
        logic    mem_wr_shift;
        logic    rd_en;
        logic    rd_next;
        logic    idx_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res_status_we;
        status_t res_status;
        logic    res_handle_we;
        logic    res_pos_we;
        logic    out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic full;
        logic scan_end;
        logic shift_end;
        logic match;
        logic out_free;
    } sts_t;

    // Every byte after the first zero byte is forced to zero.
    function automatic logic [NAME_W-1:0] normalize_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] res;
        logic              ended;
        res   = '0;
        ended = 1'b0;
        for (int b = 0; b < NAME_BYTES; b++) begin
            if (!ended) begin
                res[b*8 +: 8] = raw[b*8 +: 8];
            end
            if (raw[b*8 +: 8] == 8'd0) begin
                ended = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

### hw/rtl/nks_ctrl.sv
`timescale 1ns / 1ps

module nks_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  nks_pkg::sts_t sts,
    output nks_pkg::cmd_t cmd
);

    nks_pkg::state_t state_reg;
    nks_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nks_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nks_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = nks_pkg::ST_DECODE;
                end
            end
            nks_pkg::ST_DECODE: begin
                if (sts.op == nks_pkg::OP_LOOKUP || sts.op == nks_pkg::OP_REMOVE) begin
                    state_next = nks_pkg::ST_SCAN_CHK;
                end else begin
                    state_next = nks_pkg::ST_FINISH;
                end
            end
            nks_pkg::ST_SCAN_CHK: begin
                state_next = sts.scan_end ? nks_pkg::ST_FINISH : nks_pkg::ST_SCAN_CMP;
            end
            nks_pkg::ST_SCAN_CMP: begin
                if (!sts.match) begin
                    state_next = nks_pkg::ST_SCAN_CHK;
                end else if (sts.op == nks_pkg::OP_REMOVE) begin
                    state_next = nks_pkg::ST_SHIFT_CHK;
                end else begin
                    state_next = nks_pkg::ST_FINISH;
                end
            end
            nks_pkg::ST_SHIFT_CHK: begin
                state_next = sts.shift_end ? nks_pkg::ST_FINISH : nks_pkg::ST_SHIFT_WR;
            end
            nks_pkg::ST_SHIFT_WR: begin
                state_next = nks_pkg::ST_SHIFT_CHK;
            end
            nks_pkg::ST_FINISH: begin
                if (sts.out_free) begin
                    state_next = nks_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nks_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.res_status = nks_pkg::STATUS_OK;
        s_tready   = 1'b0;
        case (state_reg)
            nks_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            nks_pkg::ST_DECODE: begin
                if (sts.op == nks_pkg::OP_INSERT) begin
                    cmd.res_status_we = 1'b1;
                    if (sts.full) begin
                        cmd.res_status = nks_pkg::STATUS_FULL;
                    end else begin
                        cmd.mem_wr_ins = 1'b1;
                        cmd.cnt_inc    = 1'b1;
                    end
                end
            end
            nks_pkg::ST_SCAN_CHK: begin
                cmd.rd_en = !sts.scan_end;
            end
            nks_pkg::ST_SCAN_CMP: begin
                if (sts.match) begin
                    cmd.res_pos_we = 1'b1;
                    if (sts.op == nks_pkg::OP_LOOKUP) begin
                        cmd.res_status_we = 1'b1;
                        cmd.res_handle_we = 1'b1;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            nks_pkg::ST_SHIFT_CHK: begin
                if (sts.shift_end) begin
                    cmd.cnt_dec       = 1'b1;
                    cmd.res_status_we = 1'b1;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                end
            end
            nks_pkg::ST_SHIFT_WR: begin
                cmd.mem_wr_shift = 1'b1;
                cmd.idx_inc      = 1'b1;
            end
            nks_pkg::ST_FINISH: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // A result is only handed over while the output register can take it.
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while output register is occupied");

    // A request is taken only when the previous one has fully finished.
    a_accept_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> state_reg == nks_pkg::ST_DECODE)
        else $error("accepted request did not reach decode");

    a_shift_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr_shift |-> $past(cmd.rd_en) && $past(cmd.rd_next))
        else $error("shift write without the preceding read");

endmodule

### hw/rtl/nks_datapath.sv
`timescale 1ns / 1ps

module nks_datapath #(
    parameter int ENTRIES = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  nks_pkg::cmd_t                   cmd,
    output nks_pkg::sts_t                   sts,
    input  logic [nks_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [nks_pkg::OP_W-1:0]        s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [nks_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [nks_pkg::STATUS_W-1:0]    m_tuser
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    nks_pkg::entry_t mem [ENTRIES];
    nks_pkg::entry_t rd_data_reg;

    logic [nks_pkg::NAME_W-1:0]   key_reg;
    logic [nks_pkg::HANDLE_W-1:0] handle_in_reg;
    nks_pkg::op_t                 op_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W:0]   idx_plus1;

    nks_pkg::status_t             res_status_reg, res_status_next;
    logic [nks_pkg::HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic [nks_pkg::POS_W-1:0]    res_pos_reg, res_pos_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    nks_pkg::status_t              m_status_reg;
    logic [nks_pkg::HANDLE_W-1:0]  m_handle_reg;
    logic [nks_pkg::POS_W-1:0]     m_pos_reg;
    logic [nks_pkg::COUNT_W-1:0]   m_count_reg;

    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    nks_pkg::entry_t   wr_data;

    assign idx_plus1 = {1'b0, idx_reg} + (CNT_W + 1)'(1);
    assign rd_addr   = cmd.rd_next ? idx_plus1[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wr_addr   = cmd.mem_wr_ins ? count_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wr_data   = cmd.mem_wr_ins ? nks_pkg::entry_t'({handle_in_reg, key_reg})
                                      : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr_ins || cmd.mem_wr_shift) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Request capture; the name is normalised once so that stored and searched keys agree.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            key_reg       <= nks_pkg::normalize_name(s_tdata[nks_pkg::NAME_W-1:0]);
            handle_in_reg <= s_tdata[nks_pkg::NAME_W +: nks_pkg::HANDLE_W];
            op_reg        <= nks_pkg::op_t'(s_tuser);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CNT_W'(1);
        end

        idx_next = idx_reg;
        if (cmd.load_in) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_plus1[CNT_W-1:0];
        end

        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_pos_next    = res_pos_reg;
        if (cmd.load_in) begin
            res_status_next = nks_pkg::STATUS_NOTFOUND;
            res_handle_next = '0;
            res_pos_next    = '0;
        end else begin
            if (cmd.res_status_we) begin
                res_status_next = cmd.res_status;
            end
            if (cmd.res_handle_we) begin
                res_handle_next = rd_data_reg.handle;
            end
            if (cmd.res_pos_we) begin
                res_pos_next = nks_pkg::POS_W'(idx_reg);
            end
        end

        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_pos_reg    <= res_pos_next;
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_handle_reg <= res_handle_reg;
            m_pos_reg    <= res_pos_reg;
            m_count_reg  <= nks_pkg::COUNT_W'(count_reg);
        end
    end

    assign sts.op        = op_reg;
    assign sts.full      = count_reg >= CNT_W'(ENTRIES);
    assign sts.scan_end  = idx_reg >= count_reg;
    assign sts.shift_end = idx_plus1 >= {1'b0, count_reg};
    assign sts.match     = rd_data_reg.name == key_reg;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{nks_pkg::M_PAD_W{1'b0}}, m_count_reg, m_pos_reg, m_handle_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count exceeds table size");

    a_shift_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr_shift |-> idx_plus1 < {1'b0, count_reg})
        else $error("shift reaches beyond the filled part of the table");

    a_insert_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |-> count_reg < CNT_W'(ENTRIES))
        else $error("insert into a full table");

    a_remove_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_dec |-> count_reg != '0)
        else $error("remove from an empty table");

endmodule

### hw/rtl/name_keyed_session_table.sv
`timescale 1ns / 1ps

// Table of up to ENTRIES (name, handle) pairs, searched linearly from the front.
// Requests arrive on the s_ stream: s_tuser carries the operation (insert,
// lookup, remove) and s_tdata the 20-byte name and the handle. Each request
// yields exactly one result on the m_ stream: m_tuser carries the status, and
// m_tdata the handle, the position and the entry count after the request.
// Steps per request, from acceptance to the result being offered: an insert
// or unknown operation is decoded and finished; a lookup reads and then
// compares each entry from the front until a match or the end of the table;
// a remove scans as a lookup and, on a match, reads and then writes back each
// later entry one place forward before it finishes. One request is processed
// at a time. The result sits in an output register, so a stalled receiver
// only holds back the next result; a new request is taken as soon as the
// previous one has been handed to that register. Reset empties the table at
// once; no clearing pass is needed.
module name_keyed_session_table #(
    parameter int ENTRIES = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // name_bytes_0_7 [63:0], name_bytes_8_15 [127:64], name_bytes_16_19 [159:128],
    // handle_in [175:160]
    input  logic [nks_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation [1:0]
    input  logic [nks_pkg::OP_W-1:0]        s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // handle_out [15:0], position [25:16], count [36:26], zero [39:37]
    output logic [nks_pkg::M_TDATA_W-1:0]   m_tdata,
    // status [1:0]
    output logic [nks_pkg::STATUS_W-1:0]    m_tuser
);

    nks_pkg::cmd_t cmd;
    nks_pkg::sts_t sts;

    nks_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nks_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int TBL_DEPTH = 1024;
    localparam int POOL_SIZE = 16;
    localparam int RANDOM_REQUESTS = 265;
    localparam int TABLE_SOFT_MAX = 48;
    localparam logic [nks_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        nks_pkg::status_t             status;
        logic [nks_pkg::HANDLE_W-1:0] handle;
        logic [nks_pkg::POS_W-1:0]    pos;
        logic [nks_pkg::COUNT_W-1:0]  count;
    } session_reply_t;

    typedef struct packed {
        logic [nks_pkg::OP_W-1:0]     op;
        logic [nks_pkg::NAME_W-1:0]   raw;
        logic [nks_pkg::HANDLE_W-1:0] hnd;
        logic                         typed;
        session_reply_t               reply;
    } stim_row_t;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [nks_pkg::S_TDATA_W-1:0]     s_tdata;
    logic [nks_pkg::OP_W-1:0]          s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [nks_pkg::M_TDATA_W-1:0]     m_tdata;
    logic [nks_pkg::STATUS_W-1:0]      m_tuser;

    // Shadow copy of the table contents, kept in step with accepted requests.
    logic [nks_pkg::NAME_W-1:0]        stored_names   [TBL_DEPTH];
    logic [nks_pkg::HANDLE_W-1:0]      stored_handles [TBL_DEPTH];
    int                                tbl_count;

    session_reply_t                    pending_replies[$];
    session_reply_t                    want;
    int                                mismatches;

    int                                send_left, recv_left;
    bit                                send_calm, recv_calm;

    logic [nks_pkg::NAME_W-1:0]        pool_names [POOL_SIZE];
    int                                pool_len   [POOL_SIZE];

    name_keyed_session_table #(
        .ENTRIES (TBL_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The name ends at its first zero byte; anything after it does not count.
    function automatic logic [nks_pkg::NAME_W-1:0] canon_name(
            input logic [nks_pkg::NAME_W-1:0] raw);
        logic [nks_pkg::NAME_W-1:0] mask;
        bit                         open;
        mask = '0;
        open = 1'b1;
        for (int b = 0; b < nks_pkg::NAME_BYTES; b++) begin
            if (open) mask[b*8 +: 8] = 8'hFF;
            if (raw[b*8 +: 8] == 8'h00) open = 1'b0;
        end
        return raw & mask;
    endfunction

    function automatic session_reply_t predict_reply(
            input logic [nks_pkg::OP_W-1:0]     op,
            input logic [nks_pkg::NAME_W-1:0]   raw,
            input logic [nks_pkg::HANDLE_W-1:0] hnd);
        session_reply_t             r;
        logic [nks_pkg::NAME_W-1:0] key;
        int                         hit;
        r.status = nks_pkg::STATUS_NOTFOUND;
        r.handle = '0;
        r.pos    = '0;
        key      = canon_name(raw);
        hit      = -1;
        if (op == nks_pkg::OP_LOOKUP || op == nks_pkg::OP_REMOVE) begin
            for (int i = 0; i < tbl_count; i++) begin
                if (hit < 0 && stored_names[i] == key) hit = i;
            end
        end
        case (op)
            nks_pkg::OP_INSERT: begin
                if (tbl_count >= TBL_DEPTH) begin
                    r.status = nks_pkg::STATUS_FULL;
                end else begin
                    stored_names[tbl_count]   = key;
                    stored_handles[tbl_count] = hnd;
                    tbl_count++;
                    r.status = nks_pkg::STATUS_OK;
                end
            end
            nks_pkg::OP_LOOKUP: begin
                if (hit >= 0) begin
                    r.status = nks_pkg::STATUS_OK;
                    r.handle = stored_handles[hit];
                    r.pos    = nks_pkg::POS_W'(hit);
                end
            end
            nks_pkg::OP_REMOVE: begin
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < tbl_count; i++) begin
                        stored_names[i]   = stored_names[i + 1];
                        stored_handles[i] = stored_handles[i + 1];
                    end
                    tbl_count--;
                    r.status = nks_pkg::STATUS_OK;
                    r.pos    = nks_pkg::POS_W'(hit);
                end
            end
            default: ;
        endcase
        r.count = nks_pkg::COUNT_W'(tbl_count);
        return r;
    endfunction

    // Waits come in stretches: some stretches run flat out, others idle at random.
    function automatic int draw_wait(inout int left, inout bit calm);
        if (left == 0) begin
            left = int'($urandom_range(8, 40));
            calm = ($urandom_range(0, 3) == 0);
        end
        left--;
        return calm ? 0 : int'($urandom_range(0, 17));
    endfunction

    function automatic logic [nks_pkg::NAME_W-1:0] random_name(input int len, input bit junk);
        logic [nks_pkg::NAME_W-1:0] r;
        r = '0;
        for (int b = 0; b < nks_pkg::NAME_BYTES; b++) begin
            if (b < len) r[b*8 +: 8] = 8'($urandom_range(1, 255));
            else if (b > len && junk) r[b*8 +: 8] = 8'($urandom_range(0, 255));
        end
        return r;
    endfunction

    function automatic logic [nks_pkg::NAME_W-1:0] pool_raw(input int idx, input bit junk);
        logic [nks_pkg::NAME_W-1:0] r;
        r = pool_names[idx];
        if (junk) begin
            for (int b = pool_len[idx] + 1; b < nks_pkg::NAME_BYTES; b++) begin
                r[b*8 +: 8] = 8'($urandom_range(0, 255));
            end
        end
        return r;
    endfunction

    function automatic stim_row_t mk_row(input logic [nks_pkg::OP_W-1:0] op,
                                         input logic [nks_pkg::NAME_W-1:0] raw,
                                         input logic [nks_pkg::HANDLE_W-1:0] hnd,
                                         input logic typed, input nks_pkg::status_t st,
                                         input logic [nks_pkg::HANDLE_W-1:0] h,
                                         input logic [nks_pkg::POS_W-1:0] p,
                                         input logic [nks_pkg::COUNT_W-1:0] c);
        stim_row_t row;
        row.op           = op;
        row.raw          = raw;
        row.hnd          = hnd;
        row.typed        = typed;
        row.reply.status = st;
        row.reply.handle = h;
        row.reply.pos    = p;
        row.reply.count  = c;
        return row;
    endfunction

    // A row whose expected result comes from the predictor.
    function automatic stim_row_t pr_row(input logic [nks_pkg::OP_W-1:0] op,
                                         input logic [nks_pkg::NAME_W-1:0] raw,
                                         input logic [nks_pkg::HANDLE_W-1:0] hnd);
        return mk_row(op, raw, hnd, 1'b0, nks_pkg::STATUS_OK, '0, '0, '0);
    endfunction

    task automatic push_request(input logic [nks_pkg::OP_W-1:0] op,
                                input logic [nks_pkg::NAME_W-1:0] raw,
                                input logic [nks_pkg::HANDLE_W-1:0] hnd, input logic typed,
                                input session_reply_t typed_reply);
        int             gap;
        session_reply_t r;
        gap = draw_wait(send_left, send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hnd, raw};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        r = predict_reply(op, raw, hnd);
        pending_replies.push_back(typed ? typed_reply : r);
    endtask

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            if (mismatches < 10)
                $display("mismatch in %s: expected %0h, got %0h", field, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                if (mismatches < 10)
                    $display("result with no request outstanding: status %0h tdata %0h",
                             m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("handle", 32'(want.handle),
                            32'(m_tdata[nks_pkg::HANDLE_W-1:0]));
                check_field("position", 32'(want.pos),
                            32'(m_tdata[nks_pkg::HANDLE_W +: nks_pkg::POS_W]));
                check_field("count", 32'(want.count),
                            32'(m_tdata[nks_pkg::HANDLE_W+nks_pkg::POS_W +: nks_pkg::COUNT_W]));
                check_field("padding", '0,
                            32'(m_tdata[nks_pkg::M_TDATA_W-1 -: nks_pkg::M_PAD_W]));
            end
        end
    end

    // Receiver: holds tready low for a drawn number of cycles before each result.
    initial begin
        int stall;
        forever begin
            stall = draw_wait(recv_left, recv_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        stim_row_t                    rows[$];
        session_reply_t               no_reply;
        logic [nks_pkg::NAME_W-1:0]   raw;
        logic [nks_pkg::NAME_W-1:0]   name_ff, name_junk0, ab_1, ab_2, abc, long19, one_junk, one;
        logic [nks_pkg::OP_W-1:0]     op;
        int                           sel, pick, idx, b;

        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        aresetn    <= 1'b0;
        tbl_count  = 0;
        mismatches = 0;
        send_left  = 0;
        recv_left  = 0;
        no_reply   = '0;

        name_ff    = {nks_pkg::NAME_BYTES{8'hFF}};
        name_junk0 = {{19{8'hA5}}, 8'h00};
        ab_1       = {{17{8'h3C}}, 8'h00, 8'h42, 8'h41};
        ab_2       = {{17{8'hC3}}, 8'h00, 8'h42, 8'h41};
        abc        = {{17{8'h00}}, 8'h43, 8'h42, 8'h41};
        long19     = {8'h00, {19{8'h7E}}};
        one_junk   = {8'hFF, {18{8'h00}}, 8'h31};
        one        = {{19{8'h00}}, 8'h31};

        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_len[i]   = (i == 0) ? nks_pkg::NAME_BYTES :
                            (i == 1) ? 0 : int'($urandom_range(1, 20));
            pool_names[i] = random_name(pool_len[i], 1'b0);
        end

        // Empty table, unused operation, extremes of name and handle, then
        // normalisation, duplicates and the shift on removal.
        rows.push_back(mk_row(nks_pkg::OP_LOOKUP, ab_1, 16'h0000, 1'b1,
                              nks_pkg::STATUS_NOTFOUND, 16'h0000, 10'd0, 11'd0));
        rows.push_back(mk_row(nks_pkg::OP_REMOVE, ab_1, 16'h0000, 1'b1,
                              nks_pkg::STATUS_NOTFOUND, 16'h0000, 10'd0, 11'd0));
        rows.push_back(mk_row(OP_UNUSED, name_ff, 16'hFFFF, 1'b1,
                              nks_pkg::STATUS_NOTFOUND, 16'h0000, 10'd0, 11'd0));
        rows.push_back(mk_row(nks_pkg::OP_INSERT, name_ff, 16'hFFFF, 1'b1,
                              nks_pkg::STATUS_OK, 16'h0000, 10'd0, 11'd1));
        rows.push_back(mk_row(nks_pkg::OP_INSERT, '0, 16'h0000, 1'b1,
                              nks_pkg::STATUS_OK, 16'h0000, 10'd0, 11'd2));
        rows.push_back(mk_row(nks_pkg::OP_INSERT, ab_1, 16'h1234, 1'b1,
                              nks_pkg::STATUS_OK, 16'h0000, 10'd0, 11'd3));
        rows.push_back(mk_row(nks_pkg::OP_LOOKUP, name_ff, 16'h0000, 1'b1,
                              nks_pkg::STATUS_OK, 16'hFFFF, 10'd0, 11'd3));
        rows.push_back(pr_row(nks_pkg::OP_LOOKUP, name_junk0, 16'h5555));
        rows.push_back(pr_row(nks_pkg::OP_LOOKUP, ab_2, 16'h0000));
        rows.push_back(pr_row(nks_pkg::OP_INSERT, ab_2, 16'hBEEF));
        rows.push_back(pr_row(nks_pkg::OP_LOOKUP, ab_1, 16'h0000));
        rows.push_back(pr_row(nks_pkg::OP_LOOKUP, abc, 16'h0000));
        rows.push_back(pr_row(nks_pkg::OP_REMOVE, ab_2, 16'hAAAA));
        rows.push_back(pr_row(nks_pkg::OP_LOOKUP, ab_1, 16'h0000));
        rows.push_back(pr_row(nks_pkg::OP_REMOVE, name_ff, 16'h0000));
        rows.push_back(pr_row(OP_UNUSED, '0, 16'h0000));
        rows.push_back(pr_row(nks_pkg::OP_LOOKUP, long19, 16'h0000));
        rows.push_back(pr_row(nks_pkg::OP_INSERT, long19, 16'h8001));
        rows.push_back(pr_row(nks_pkg::OP_INSERT, one_junk, 16'h7FFE));
        rows.push_back(pr_row(nks_pkg::OP_LOOKUP, one, 16'h0000));
        rows.push_back(pr_row(nks_pkg::OP_LOOKUP, long19, 16'h0000));
        rows.push_back(pr_row(nks_pkg::OP_REMOVE, '0, 16'h0000));
        rows.push_back(pr_row(nks_pkg::OP_REMOVE, one, 16'h0000));
        rows.push_back(pr_row(nks_pkg::OP_REMOVE, long19, 16'h0000));
        rows.push_back(pr_row(nks_pkg::OP_REMOVE, ab_1, 16'h0000));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i])
            push_request(rows[i].op, rows[i].raw, rows[i].hnd, rows[i].typed, rows[i].reply);

        // Random requests mostly reuse a small pool of names so that lookups and
        // removals hit, with duplicates; the table is kept short to bound the scan.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            sel = int'($urandom_range(0, 99));
            if (sel < 5) op = OP_UNUSED;
            else if (tbl_count >= TABLE_SOFT_MAX)
                op = (sel < 60) ? nks_pkg::OP_REMOVE : nks_pkg::OP_LOOKUP;
            else if (sel < 45) op = nks_pkg::OP_INSERT;
            else if (sel < 75) op = nks_pkg::OP_LOOKUP;
            else op = nks_pkg::OP_REMOVE;
            pick = int'($urandom_range(0, 9));
            idx  = int'($urandom_range(0, POOL_SIZE - 1));
            if (pick < 7) begin
                raw = pool_raw(idx, 1'($urandom_range(0, 1)));
            end else if (pick < 9) begin
                raw = pool_raw(idx, 1'b0);
                b   = int'($urandom_range(0, nks_pkg::NAME_BYTES - 1));
                raw[b*8 +: 8] = raw[b*8 +: 8] ^ (8'h01 << $urandom_range(0, 7));
            end else begin
                raw = random_name(int'($urandom_range(0, 20)), 1'($urandom_range(0, 1)));
            end
            push_request(op, raw, 16'($urandom_range(0, 65535)), 1'b0, no_reply);
        end
        s_tvalid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
hw/rtl/nks_pkg.sv
hw/rtl/nks_ctrl.sv
hw/rtl/nks_datapath.sv
hw/rtl/name_keyed_session_table.sv
sim/tb_top.sv
